// ----- sv/bsq_pkg.sv -----
package bsq_pkg;

  localparam int MAX_BUZZERS_DEF = 256;

  localparam logic [1:0] OP_GIVE  = 2'd0;
  localparam logic [1:0] OP_SEAT  = 2'd1;
  localparam logic [1:0] OP_KICK  = 2'd2;
  localparam logic [1:0] OP_FRONT = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_NOT_QUEUED = 2'd2;
  localparam logic [1:0] ST_ALL_IN_USE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXE1,
    S_EXE2
  } state_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic exe1;
    logic exe2;
  } cmd_t;

endpackage

// ----- sv/bsq_ram.sv -----
module bsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bsq_ctrl.sv -----
module bsq_ctrl import bsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_READ;
      end
      S_READ: state_next = S_EXE1;
      S_EXE1: state_next = S_EXE2;
      S_EXE2: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_READ: cmd.decide = 1'b1;
      S_EXE1: cmd.exe1   = 1'b1;
      S_EXE2: cmd.exe2   = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- sv/bsq_dp.sv -----
module bsq_dp import bsq_pkg::*; #(
  parameter int MAX_BUZZERS = MAX_BUZZERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic [1:0] op,
  input  logic [7:0] buzzer_id,
  output logic       result_valid,
  output logic [7:0] result_id,
  output logic [1:0] status,
  output logic [8:0] queue_length
);

  localparam int IW = $clog2(MAX_BUZZERS);
  localparam int CW = $clog2(MAX_BUZZERS + 1);
  localparam int QN = (MAX_BUZZERS < 256) ? MAX_BUZZERS : 256;
  localparam int QW = $clog2(QN);

  logic [1:0]    op_r;
  logic [7:0]    bid_r;
  logic [IW-1:0] id_r;
  logic [1:0]    st_r;
  logic          from_free;
  logic          is_head;
  logic [IW-1:0] head, tail, fhead, ftail;
  logic [CW-1:0] fcnt, icnt, wcnt;
  logic [QN-1:0] inq;

  logic [IW-1:0] nx, pv;
  logic          n_we, p_we;
  logic [IW-1:0] n_waddr, n_wdata, p_waddr, p_wdata, n_raddr;

  logic [1:0]    st_next;
  logic [IW-1:0] id_next;
  logic          bid_ok;
  logic          at_head, at_tail, id_inq;

  assign bid_ok  = (32'(bid_r) < QN) && inq[QW'(bid_r)];
  assign at_head = (id_r == head);
  assign at_tail = (id_r == tail);
  assign id_inq  = (32'(id_r) < QN);

  // read addresses and outcome of the command
  always_comb begin
    st_next = ST_OK;
    id_next = IW'(bid_r);
    n_raddr = IW'(bid_r);
    case (op_r)
      OP_GIVE: begin
        n_raddr = fhead;
        if (fcnt != '0) id_next = fhead;
        else if (32'(icnt) < MAX_BUZZERS) id_next = icnt[IW-1:0];
        else st_next = ST_ALL_IN_USE;
      end
      OP_SEAT: begin
        n_raddr = head;
        id_next = head;
        if (wcnt == '0) st_next = ST_EMPTY;
      end
      default: begin
        if (!bid_ok) st_next = ST_NOT_QUEUED;
      end
    endcase
  end

  // link writes
  always_comb begin
    n_we = 1'b0; n_waddr = nx; n_wdata = pv;
    p_we = 1'b0; p_waddr = nx; p_wdata = pv;
    if (st_r == ST_OK) begin
      if (cmd.exe1) begin
        if (op_r == OP_GIVE) begin
          if (wcnt != '0) begin
            n_we = 1'b1; n_waddr = tail; n_wdata = id_r;
            p_we = 1'b1; p_waddr = id_r; p_wdata = tail;
          end
        end else if (op_r != OP_SEAT && !(op_r == OP_FRONT && is_head)) begin
          if (!at_head && !at_tail) begin
            n_we = 1'b1; n_waddr = pv; n_wdata = nx;
            p_we = 1'b1; p_waddr = nx; p_wdata = pv;
          end
        end
      end
      if (cmd.exe2) begin
        if (op_r == OP_SEAT || op_r == OP_KICK) begin
          if (fcnt != '0) begin
            n_we = 1'b1; n_waddr = ftail; n_wdata = id_r;
          end
        end else if (op_r == OP_FRONT && !is_head) begin
          n_we = 1'b1; n_waddr = id_r; n_wdata = head;
          p_we = 1'b1; p_waddr = head; p_wdata = id_r;
        end
      end
    end
  end

  bsq_ram #(.WIDTH(IW), .DEPTH(MAX_BUZZERS)) u_next (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .re(cmd.decide), .raddr(n_raddr), .rdata(nx)
  );

  bsq_ram #(.WIDTH(IW), .DEPTH(MAX_BUZZERS)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(cmd.decide), .raddr(IW'(bid_r)), .rdata(pv)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      bid_r <= buzzer_id;
    end
    if (cmd.decide) begin
      st_r      <= st_next;
      id_r      <= id_next;
      from_free <= (fcnt != '0);
      is_head   <= (id_next == head);
    end
    if (cmd.exe2) begin
      result_id    <= (st_r == ST_OK && (op_r == OP_GIVE || op_r == OP_SEAT)) ? 8'(id_r) : '0;
      status       <= st_r;
      queue_length <= 9'(wcnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; fhead <= '0; ftail <= '0;
      fcnt <= '0; icnt <= '0; wcnt <= '0;
      inq  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.exe2;
      if (st_r == ST_OK && cmd.exe1) begin
        case (op_r)
          OP_GIVE: begin
            if (from_free) begin
              fcnt <= fcnt - CW'(1);
              if (fcnt != CW'(1)) fhead <= nx;
            end else begin
              icnt <= icnt + CW'(1);
            end
            if (wcnt == '0) head <= id_r;
            tail <= id_r;
            if (id_inq) inq[QW'(id_r)] <= 1'b1;
            wcnt <= wcnt + CW'(1);
          end
          OP_SEAT: begin
            if (!at_tail) head <= nx;
            if (id_inq) inq[QW'(id_r)] <= 1'b0;
            wcnt <= wcnt - CW'(1);
          end
          OP_KICK: begin
            if (at_head && !at_tail) head <= nx;
            else if (at_tail && !at_head) tail <= pv;
            if (id_inq) inq[QW'(id_r)] <= 1'b0;
            wcnt <= wcnt - CW'(1);
          end
          default: begin
            // front move: unlink only, the id stays counted
            if (!is_head && at_tail) tail <= pv;
          end
        endcase
      end
      if (st_r == ST_OK && cmd.exe2) begin
        if (op_r == OP_SEAT || op_r == OP_KICK) begin
          if (fcnt == '0) fhead <= id_r;
          ftail <= id_r;
          fcnt  <= fcnt + CW'(1);
        end else if (op_r == OP_FRONT && !is_head) begin
          head <= id_r;
        end
      end
    end
  end

endmodule

// ----- sv/buzzer_service_queue.sv -----
// buzzer service queue: waiting list as doubly linked index arrays plus a fifo of freed ids
// the result strobe is registered in the second write step and rises in the cycle busy falls
// a new command is taken only when idle, after the link ram read and the two write steps
// a new command may be started in the same cycle the previous result is strobed
// reset (sync, active high) empties the queue and free list; link rams need no clearing
// the receiver cannot stall: each result beat is shown for exactly one cycle
module buzzer_service_queue import bsq_pkg::*; #(
  parameter int MAX_BUZZERS = MAX_BUZZERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // command beat, taken when start is high and busy is low
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] buzzer_id,
  // result beat, valid for one cycle
  output logic       result_valid,
  output logic [7:0] result_id,
  output logic [1:0] status,
  output logic [8:0] queue_length
);

  cmd_t cmd;

  // sequencer: idle, link read, first write step, second write step
  bsq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  // list pointers, counters, membership bits and the two link rams
  bsq_dp #(.MAX_BUZZERS(MAX_BUZZERS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .op          (op),
    .buzzer_id   (buzzer_id),
    .result_valid(result_valid),
    .result_id   (result_id),
    .status      (status),
    .queue_length(queue_length)
  );

endmodule
